[design/asst_pkg.sv]
// Shared types and constants for the adaptive step size tuner.
package asst_pkg;

    // Transaction function codes
    localparam logic [1:0] FUNC_UPDATE  = 2'd0;
    localparam logic [1:0] FUNC_CAP     = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;
    localparam logic [1:0] FUNC_HOLD    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_INIT_LOG = 2'd0;
    localparam logic [1:0] REG_MIN_LOG  = 2'd1;
    localparam logic [1:0] REG_MAX_LOG  = 2'd2;
    localparam logic [1:0] REG_TARGET   = 2'd3;

    // ln 2 and one in Q.56
    localparam logic [55:0] LN2_Q56 = 56'hB17217F7D1CF7A;
    localparam logic [63:0] Q56_ONE = 64'h0100_0000_0000_0000;

    // Taylor series stops at this term index, or earlier once a term is zero
    localparam logic [5:0] TAYLOR_LIMIT = 6'd40;

    typedef struct packed {
        logic latch_in;
        logic apply_func;
        logic div_start;
        logic div_mean;
        logic apply_delta;
        logic exp_start;
        logic tay_init;
        logic mul_start;
        logic dvn_start;
        logic tay_add;
        logic exp_fin;
        logic mean_fin;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       div_busy;
        logic       red_busy;
        logic       mul_busy;
        logic       dvn_busy;
        logic       tay_go;
        logic       count_zero;
    } status_t;

endpackage

[design/asst_dp.sv]
// Datapath: state, config registers, shared divider, exp unit, output registers.
module asst_dp #(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [1:0]                cfg_index,
    input  logic [FRAC_BITS+4:0]      cfg_data,
    input  logic [1:0]                func,
    input  logic [FRAC_BITS:0]        accept_prob,
    input  logic [31:0]               gain_cap,
    input  asst_pkg::cmd_t            cmd,
    output asst_pkg::status_t         status,
    output logic [FRAC_BITS+23:0]     step_size,
    output logic signed [FRAC_BITS+4:0] log_step,
    output logic [FRAC_BITS:0]        mean_accept
);

    localparam int LOG_W  = FRAC_BITS + 5;
    localparam int PROB_W = FRAC_BITS + 1;
    localparam int STEP_W = FRAC_BITS + 24;
    localparam int SUM_W  = COUNT_BITS + FRAC_BITS;
    localparam int CAP_W  = (COUNT_BITS > 32) ? COUNT_BITS : 32;
    localparam int DCNT_W = $clog2(SUM_W);
    localparam int SH0    = 56 - FRAC_BITS;

    localparam logic [PROB_W-1:0]     PROB_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [LOG_W-1:0]      LOG_MIN  = {1'b1, {(LOG_W-1){1'b0}}};
    localparam logic [LOG_W-1:0]      LOG_MAX  = {1'b0, {(LOG_W-1){1'b1}}};
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [STEP_W-1:0]     STEP_ONE = {23'd0, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [63:0]           TGT64    = (64'd29491 << FRAC_BITS) >> 16;
    localparam logic [PROB_W-1:0]     TGT_RST  = TGT64[PROB_W-1:0];
    localparam logic [7:0]            SH0_V    = 8'(SH0);

    // config
    logic [LOG_W-1:0]  init_log_reg, init_log_next;
    logic [LOG_W-1:0]  min_log_reg, min_log_next;
    logic [LOG_W-1:0]  max_log_reg, max_log_next;
    logic [PROB_W-1:0] target_reg, target_next;
    // latched transaction
    logic [1:0]        func_reg, func_next;
    logic [PROB_W-1:0] prob_reg, prob_next;
    logic [31:0]       cap_reg, cap_next;
    // tuner state
    logic [LOG_W-1:0]      cur_log_reg, cur_log_next;
    logic [COUNT_BITS-1:0] gain_reg, gain_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [STEP_W-1:0]     cur_step_reg, cur_step_next;
    logic [PROB_W-1:0]     mean_reg, mean_next;
    logic                  neg_reg, neg_next;
    // shared restoring divider
    logic [SUM_W-1:0]      dvd_reg, dvd_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0] dsr_reg, dsr_next;
    logic [DCNT_W-1:0]     dcnt_reg, dcnt_next;
    logic                  dbusy_reg, dbusy_next;
    // range reduction
    logic signed [60:0]    r_reg, r_next;
    logic signed [6:0]     q_reg, q_next;
    logic                  rbusy_reg, rbusy_next;
    // Taylor series
    logic [63:0]           tsum_reg, tsum_next;
    logic [63:0]           term_reg, term_next;
    logic [5:0]            n_reg, n_next;
    // partial product multiplier
    logic [127:0]          acc_reg, acc_next;
    logic [63:0]           prod_reg, prod_next;
    logic [1:0]            psh_reg, psh_next;
    logic [2:0]            mcnt_reg, mcnt_next;
    logic                  mbusy_reg, mbusy_next;
    // divide by term index, eight bits a cycle
    logic [63:0]           nd_reg, nd_next;
    logic [5:0]            nrem_reg, nrem_next;
    logic [2:0]            ncnt_reg, ncnt_next;
    logic                  nbusy_reg, nbusy_next;
    // output payload
    logic [STEP_W-1:0]     out_step_reg, out_step_next;
    logic [LOG_W-1:0]      out_log_reg, out_log_next;
    logic [PROB_W-1:0]     out_mean_reg, out_mean_next;

    // combinational helpers
    logic [PROB_W-1:0]        p_clamp;
    logic signed [PROB_W:0]   diff;
    logic [PROB_W:0]          mag_full;
    logic signed [LOG_W:0]    qext, sdelta, s_sum, max_ext, min_ext;
    logic [LOG_W-1:0]         s_clamp;
    logic [COUNT_BITS:0]      rem_sh;
    logic                     div_ge;
    logic                     mean_rnd;
    logic [SUM_W-1:0]         mean_q;
    logic [CAP_W-1:0]         cap_ext, gain_ext;
    logic signed [60:0]       ln2_ext;
    logic [63:0]              mul_b;
    logic [31:0]              a_part, b_part;
    logic [127:0]             prod_sh;
    logic [6:0]               nrem_v;
    logic [63:0]              nd_v;
    logic signed [7:0]        sh;
    logic [5:0]               sh_m1;
    logic [63:0]              rnd_tmp, shifted;
    logic [STEP_W-1:0]        exp_val;

    function automatic logic gain_cap_zero(input logic [31:0] v);
        gain_cap_zero = (v == 32'd0);
    endfunction

    always_comb
    begin
        p_clamp  = (prob_reg > PROB_ONE) ? PROB_ONE : prob_reg;
        diff     = $signed({1'b0, p_clamp}) - $signed({1'b0, target_reg});
        mag_full = diff[PROB_W] ? $unsigned(-diff) : $unsigned(diff);

        qext    = $signed({{(LOG_W+1-PROB_W){1'b0}}, dvd_reg[PROB_W-1:0]});
        sdelta  = neg_reg ? -qext : qext;
        s_sum   = $signed({cur_log_reg[LOG_W-1], cur_log_reg}) + sdelta;
        max_ext = $signed({max_log_reg[LOG_W-1], max_log_reg});
        min_ext = $signed({min_log_reg[LOG_W-1], min_log_reg});
        if (s_sum > max_ext)
        begin
            s_clamp = max_log_reg;
        end
        else if (s_sum < min_ext)
        begin
            s_clamp = min_log_reg;
        end
        else
        begin
            s_clamp = s_sum[LOG_W-1:0];
        end

        rem_sh   = {rem_reg, dvd_reg[SUM_W-1]};
        div_ge   = rem_sh >= {1'b0, dsr_reg};
        mean_rnd = {rem_reg, 1'b0} >= {1'b0, count_reg};
        mean_q   = dvd_reg + SUM_W'(mean_rnd);

        cap_ext  = (gain_cap_zero(cap_reg)) ? CAP_W'(1) : CAP_W'(cap_reg);
        gain_ext = CAP_W'(gain_reg);

        ln2_ext  = $signed({5'd0, asst_pkg::LN2_Q56});

        mul_b  = {8'd0, r_reg[55:0]};
        a_part = mcnt_reg[0] ? term_reg[63:32] : term_reg[31:0];
        b_part = mcnt_reg[1] ? mul_b[63:32] : mul_b[31:0];
        case (psh_reg)
            2'd0:    prod_sh = {64'd0, prod_reg};
            2'd1:    prod_sh = {32'd0, prod_reg, 32'd0};
            default: prod_sh = {prod_reg, 64'd0};
        endcase

        nrem_v = {1'b0, nrem_reg};
        nd_v   = nd_reg;
        for (int i = 0; i < 8; i++)
        begin
            nrem_v = {nrem_v[5:0], nd_v[63]};
            nd_v   = {nd_v[62:0], 1'b0};
            if (nrem_v >= {1'b0, n_reg})
            begin
                nrem_v  = nrem_v - {1'b0, n_reg};
                nd_v[0] = 1'b1;
            end
        end

        sh      = $signed(SH0_V) - $signed({q_reg[6], q_reg});
        sh_m1   = sh[5:0] - 6'd1;
        rnd_tmp = tsum_reg + (64'd1 << sh_m1);
        shifted = rnd_tmp >> sh[5:0];
        if (sh >= 8'sd64)
        begin
            exp_val = '0;
        end
        else if (sh <= 8'sd0)
        begin
            exp_val = {STEP_W{1'b1}};
        end
        else
        begin
            exp_val = shifted[STEP_W-1:0];
        end
    end

    always_comb
    begin
        init_log_next = init_log_reg;
        min_log_next  = min_log_reg;
        max_log_next  = max_log_reg;
        target_next   = target_reg;
        func_next     = func_reg;
        prob_next     = prob_reg;
        cap_next      = cap_reg;
        cur_log_next  = cur_log_reg;
        gain_next     = gain_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        cur_step_next = cur_step_reg;
        mean_next     = mean_reg;
        neg_next      = neg_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        dsr_next      = dsr_reg;
        dcnt_next     = dcnt_reg;
        dbusy_next    = dbusy_reg;
        r_next        = r_reg;
        q_next        = q_reg;
        rbusy_next    = rbusy_reg;
        tsum_next     = tsum_reg;
        term_next     = term_reg;
        n_next        = n_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        psh_next      = psh_reg;
        mcnt_next     = mcnt_reg;
        mbusy_next    = mbusy_reg;
        nd_next       = nd_reg;
        nrem_next     = nrem_reg;
        ncnt_next     = ncnt_reg;
        nbusy_next    = nbusy_reg;
        out_step_next = out_step_reg;
        out_log_next  = out_log_reg;
        out_mean_next = out_mean_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                asst_pkg::REG_INIT_LOG: init_log_next = cfg_data;
                asst_pkg::REG_MIN_LOG:  min_log_next  = cfg_data;
                asst_pkg::REG_MAX_LOG:  max_log_next  = cfg_data;
                asst_pkg::REG_TARGET:   target_next   = cfg_data[PROB_W-1:0];
                default:                target_next   = target_reg;
            endcase
        end

        if (cmd.latch_in)
        begin
            func_next = func;
            prob_next = accept_prob;
            cap_next  = gain_cap;
        end

        if (cmd.apply_func)
        begin
            case (func_reg)
                asst_pkg::FUNC_UPDATE:
                begin
                    neg_next = diff[PROB_W];
                    if (count_reg < CNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + SUM_W'(p_clamp);
                    end
                end
                asst_pkg::FUNC_CAP:
                begin
                    if (gain_ext > cap_ext)
                    begin
                        gain_next = cap_ext[COUNT_BITS-1:0];
                    end
                end
                asst_pkg::FUNC_RESTART:
                begin
                    cur_log_next = init_log_reg;
                    gain_next    = COUNT_BITS'(1);
                    count_next   = '0;
                    sum_next     = '0;
                end
                default:
                begin
                    neg_next = neg_reg;
                end
            endcase
        end

        // shared divider: gain division for the update, then the mean
        if (cmd.div_start)
        begin
            if (cmd.div_mean)
            begin
                dvd_next = sum_reg;
                dsr_next = count_reg;
            end
            else
            begin
                dvd_next = SUM_W'(mag_full[PROB_W-1:0]);
                dsr_next = gain_reg;
            end
            rem_next   = '0;
            dcnt_next  = '0;
            dbusy_next = 1'b1;
        end
        else if (dbusy_reg)
        begin
            rem_next  = div_ge ? rem_sh[COUNT_BITS-1:0] - dsr_reg : rem_sh[COUNT_BITS-1:0];
            dvd_next  = {dvd_reg[SUM_W-2:0], div_ge};
            dcnt_next = dcnt_reg + 1'b1;
            if (dcnt_reg == DCNT_W'(SUM_W - 1))
            begin
                dbusy_next = 1'b0;
            end
        end

        if (cmd.apply_delta)
        begin
            cur_log_next = s_clamp;
            if (gain_reg < CNT_MAX)
            begin
                gain_next = gain_reg + 1'b1;
            end
        end

        // reduce x = s * ln2 units to q and r in [0, ln2)
        if (cmd.exp_start)
        begin
            r_next     = $signed({cur_log_reg, {SH0{1'b0}}});
            q_next     = '0;
            rbusy_next = 1'b1;
        end
        else if (rbusy_reg)
        begin
            if (r_reg < 0)
            begin
                r_next = r_reg + ln2_ext;
                q_next = q_reg - 7'sd1;
            end
            else if (r_reg >= ln2_ext)
            begin
                r_next = r_reg - ln2_ext;
                q_next = q_reg + 7'sd1;
            end
            else
            begin
                rbusy_next = 1'b0;
            end
        end

        if (cmd.tay_init)
        begin
            tsum_next = asst_pkg::Q56_ONE;
            term_next = asst_pkg::Q56_ONE;
            n_next    = 6'd1;
        end
        else if (cmd.tay_add)
        begin
            term_next = nd_reg;
            tsum_next = tsum_reg + nd_reg;
            n_next    = n_reg + 6'd1;
        end

        // term * r over four 32x32 partial products, product registered
        if (cmd.mul_start)
        begin
            acc_next   = '0;
            mcnt_next  = '0;
            mbusy_next = 1'b1;
        end
        else if (mbusy_reg)
        begin
            if (mcnt_reg != 3'd4)
            begin
                prod_next = {32'd0, a_part} * {32'd0, b_part};
                psh_next  = 2'(mcnt_reg[0]) + 2'(mcnt_reg[1]);
            end
            if (mcnt_reg != 3'd0)
            begin
                acc_next = acc_reg + prod_sh;
            end
            if (mcnt_reg == 3'd4)
            begin
                mbusy_next = 1'b0;
            end
            mcnt_next = mcnt_reg + 3'd1;
        end

        if (cmd.dvn_start)
        begin
            nd_next    = acc_reg[119:56];
            nrem_next  = '0;
            ncnt_next  = '0;
            nbusy_next = 1'b1;
        end
        else if (nbusy_reg)
        begin
            nd_next   = nd_v;
            nrem_next = nrem_v[5:0];
            ncnt_next = ncnt_reg + 3'd1;
            if (ncnt_reg == 3'd7)
            begin
                nbusy_next = 1'b0;
            end
        end

        if (cmd.exp_fin)
        begin
            cur_step_next = exp_val;
        end

        if (cmd.mean_fin)
        begin
            mean_next = (count_reg == '0) ? '0 : mean_q[PROB_W-1:0];
        end

        if (cmd.out_load)
        begin
            out_step_next = cur_step_reg;
            out_log_next  = cur_log_reg;
            out_mean_next = mean_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_log_reg <= '0;
            min_log_reg  <= LOG_MIN;
            max_log_reg  <= LOG_MAX;
            target_reg   <= TGT_RST;
            cur_log_reg  <= '0;
            gain_reg     <= COUNT_BITS'(1);
            count_reg    <= '0;
            sum_reg      <= '0;
            cur_step_reg <= STEP_ONE;
            dbusy_reg    <= 1'b0;
            dcnt_reg     <= '0;
            rbusy_reg    <= 1'b0;
            mbusy_reg    <= 1'b0;
            mcnt_reg     <= '0;
            nbusy_reg    <= 1'b0;
            ncnt_reg     <= '0;
        end
        else
        begin
            init_log_reg <= init_log_next;
            min_log_reg  <= min_log_next;
            max_log_reg  <= max_log_next;
            target_reg   <= target_next;
            cur_log_reg  <= cur_log_next;
            gain_reg     <= gain_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            cur_step_reg <= cur_step_next;
            dbusy_reg    <= dbusy_next;
            dcnt_reg     <= dcnt_next;
            rbusy_reg    <= rbusy_next;
            mbusy_reg    <= mbusy_next;
            mcnt_reg     <= mcnt_next;
            nbusy_reg    <= nbusy_next;
            ncnt_reg     <= ncnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        prob_reg     <= prob_next;
        cap_reg      <= cap_next;
        mean_reg     <= mean_next;
        neg_reg      <= neg_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dsr_reg      <= dsr_next;
        r_reg        <= r_next;
        q_reg        <= q_next;
        tsum_reg     <= tsum_next;
        term_reg     <= term_next;
        n_reg        <= n_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        psh_reg      <= psh_next;
        nd_reg       <= nd_next;
        nrem_reg     <= nrem_next;
        out_step_reg <= out_step_next;
        out_log_reg  <= out_log_next;
        out_mean_reg <= out_mean_next;
    end

    assign status.func       = func_reg;
    assign status.div_busy   = dbusy_reg;
    assign status.red_busy   = rbusy_reg;
    assign status.mul_busy   = mbusy_reg;
    assign status.dvn_busy   = nbusy_reg;
    assign status.tay_go     = (n_reg < asst_pkg::TAYLOR_LIMIT) && (term_reg != 64'd0);
    assign status.count_zero = (count_reg == '0);

    assign step_size   = out_step_reg;
    assign log_step    = out_log_reg;
    assign mean_accept = out_mean_reg;

endmodule

[design/asst_ctrl.sv]
// Controller: sequences one transaction through the datapath units.
module asst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  asst_pkg::status_t status,
    output asst_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_OP    = 4'd1;
    localparam logic [3:0] S_DDIV  = 4'd2;
    localparam logic [3:0] S_UPD   = 4'd3;
    localparam logic [3:0] S_EXPS  = 4'd4;
    localparam logic [3:0] S_RED   = 4'd5;
    localparam logic [3:0] S_TCHK  = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_DVN   = 4'd8;
    localparam logic [3:0] S_EFIN  = 4'd9;
    localparam logic [3:0] S_MEAN  = 4'd10;
    localparam logic [3:0] S_MWAIT = 4'd11;
    localparam logic [3:0] S_MFIN  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_OP;
                end
            end
            S_OP:
            begin
                cmd.apply_func = 1'b1;
                case (status.func)
                    asst_pkg::FUNC_UPDATE:
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DDIV;
                    end
                    asst_pkg::FUNC_RESTART: state_next = S_EXPS;
                    default:                state_next = S_MEAN;
                endcase
            end
            S_DDIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.apply_delta = 1'b1;
                state_next      = S_EXPS;
            end
            S_EXPS:
            begin
                cmd.exp_start = 1'b1;
                state_next    = S_RED;
            end
            S_RED:
            begin
                if (!status.red_busy)
                begin
                    cmd.tay_init = 1'b1;
                    state_next   = S_TCHK;
                end
            end
            S_TCHK:
            begin
                if (status.tay_go)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL;
                end
                else
                begin
                    state_next = S_EFIN;
                end
            end
            S_MUL:
            begin
                if (!status.mul_busy)
                begin
                    cmd.dvn_start = 1'b1;
                    state_next    = S_DVN;
                end
            end
            S_DVN:
            begin
                if (!status.dvn_busy)
                begin
                    cmd.tay_add = 1'b1;
                    state_next  = S_TCHK;
                end
            end
            S_EFIN:
            begin
                cmd.exp_fin = 1'b1;
                state_next  = S_MEAN;
            end
            S_MEAN:
            begin
                if (status.count_zero)
                begin
                    state_next = S_MFIN;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_mean  = 1'b1;
                    state_next    = S_MWAIT;
                end
            end
            S_MWAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_MFIN;
                end
            end
            S_MFIN:
            begin
                cmd.mean_fin = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[design/adaptive_step_size_tuner_unit.sv]
// Top level of the adaptive step size tuner: controller plus datapath.
// Work per transaction: func 1 and 3 run the mean division (one bit a cycle);
// func 0 adds a second such division for the gain step; func 0 and 2 add the
// exp unit: up to 24 reduction steps plus, per Taylor term, four 32x32 partial
// products, then an 8-bit-per-cycle divide by n.
// One transaction at a time; output is registered, so a new one is taken while a
// result waits. Reset (async, active low) restores the config and tuner state.
module adaptive_step_size_tuner_unit #(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration writes, no handshake
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_index,
    input  logic [FRAC_BITS+4:0]        cfg_data,
    // input transaction
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  func,
    input  logic [FRAC_BITS:0]          accept_prob,
    input  logic [31:0]                 gain_cap,
    // result transaction
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [FRAC_BITS+23:0]       step_size,
    output logic signed [FRAC_BITS+4:0] log_step,
    output logic [FRAC_BITS:0]          mean_accept
);

    asst_pkg::cmd_t    cmd;
    asst_pkg::status_t status;

    // Sequencer: walks op, gain division, exp reduction, Taylor loop, mean division.
    asst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath holds the tuner state; the input fields are sampled on cmd.latch_in.
    asst_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .accept_prob (accept_prob),
        .gain_cap    (gain_cap),
        .cmd         (cmd),
        .status      (status),
        .step_size   (step_size),
        .log_step    (log_step),
        .mean_accept (mean_accept)
    );

endmodule
